// File: src/tbr_pkg.sv
// Shared types and constants for the tetrahedron box and bounding-radius pipeline.
// No dependencies; imported by tbr_isqrt, tetrahedron_box_and_radius and the testbench.
package tbr_pkg;

    // Coordinate width, squared-distance width and square-root stage count
    localparam int COORD_BITS  = 24;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int ROOT_STAGES = COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Input word: four vertices, three axes each
    typedef struct packed {
        coord_t v0_x;
        coord_t v0_y;
        coord_t v0_z;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
        coord_t v3_x;
        coord_t v3_y;
        coord_t v3_z;
    } tet_t;

    // Box side-band carried alongside the square-root pipe
    typedef struct packed {
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } box_t;

    // Result word
    typedef struct packed {
        coord_t                  box_min_x;
        coord_t                  box_min_y;
        coord_t                  box_min_z;
        coord_t                  box_max_x;
        coord_t                  box_max_y;
        coord_t                  box_max_z;
        logic [COORD_BITS-1:0]   sphere_radius;
    } bound_t;

endpackage

// File: src/tbr_isqrt.sv
// Fully pipelined integer square root, one result bit per stage, with box side-band.
// Depends on tbr_pkg.
module tbr_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [tbr_pkg::SQ_BITS-1:0]    radicand,
    input  tbr_pkg::box_t                  box_in,
    output logic                           out_valid,
    output logic [tbr_pkg::COORD_BITS-1:0] root,
    output tbr_pkg::box_t                  box_out
);
    import tbr_pkg::*;

    // remainder never exceeds 2*root, shifted by two bits before each trial
    localparam int RW = COORD_BITS + 3;
    localparam int NS = ROOT_STAGES;

    logic                  vld_reg  [NS];
    logic [RW-1:0]         rem_reg  [NS];
    logic [COORD_BITS-1:0] root_reg [NS];
    logic [SQ_BITS-1:0]    x_reg    [NS-1];
    box_t                  box_reg  [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic [RW-1:0]         rem_prev;
            logic [RW-1:0]         rem_sh;
            logic [RW-1:0]         trial;
            logic [RW-1:0]         rem_next;
            logic [COORD_BITS-1:0] root_prev;
            logic [COORD_BITS-1:0] root_next;
            logic [SQ_BITS-1:0]    x_prev;
            logic                  vld_prev;
            box_t                  box_prev;

            // stage inputs: the pipe entry or the previous stage
            if (k == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign x_prev    = radicand;
                assign vld_prev  = in_valid;
                assign box_prev  = box_in;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign x_prev    = x_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
                assign box_prev  = box_reg[k-1];
            end

            // bring down two radicand bits, trial-subtract 4*root+1
            always_comb
            begin
                rem_sh = {rem_prev[RW-3:0], x_prev[SQ_BITS-1 -: 2]};
                trial  = RW'({root_prev, 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[COORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[COORD_BITS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else
                    vld_reg[k] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                box_reg[k]  <= box_prev;
            end

            // remaining radicand bits, not needed past the last stage
            if (k < NS - 1)
            begin : g_shift
                always_ff @(posedge clk)
                begin
                    x_reg[k] <= x_prev << 2;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign box_out   = box_reg[NS-1];

    // final remainder x - r*r stays within 2r, else the root is too small
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] |-> rem_reg[NS-1] <= RW'({root_reg[NS-1], 1'b0}))
        else $error("square root remainder above 2*root");

    // first step sees at most a two-bit value
    a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> rem_reg[0] <= RW'(2'd2))
        else $error("first square root step remainder out of range");

endmodule

// File: src/tetrahedron_box_and_radius.sv
// Five front stages, then one square-root stage per radius bit, lead from an accepted
// start to the done strobe; throughput one word per cycle.
// busy is held low: the pipeline takes a word every cycle and the receiver cannot stall.
// Reset clears only the valid bits; data registers are not reset.
// Top level: box min/max, doubled offsets, squares, sums, max, then tbr_isqrt.
// Depends on tbr_pkg and tbr_isqrt.
module tetrahedron_box_and_radius (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tbr_pkg::tet_t   tet,
    output logic            busy,
    output logic            done,
    output tbr_pkg::bound_t bound
);
    import tbr_pkg::*;

    localparam int W = COORD_BITS;

    // never back-pressures
    assign busy = 1'b0;

    // ---------------- stage 1: per-axis min/max ----------------
    coord_t p_in [4][3];

    assign p_in[0][0] = tet.v0_x;
    assign p_in[0][1] = tet.v0_y;
    assign p_in[0][2] = tet.v0_z;
    assign p_in[1][0] = tet.v1_x;
    assign p_in[1][1] = tet.v1_y;
    assign p_in[1][2] = tet.v1_z;
    assign p_in[2][0] = tet.v2_x;
    assign p_in[2][1] = tet.v2_y;
    assign p_in[2][2] = tet.v2_z;
    assign p_in[3][0] = tet.v3_x;
    assign p_in[3][1] = tet.v3_y;
    assign p_in[3][2] = tet.v3_z;

    coord_t lo_next [3];
    coord_t hi_next [3];
    coord_t p1_reg  [4][3];
    coord_t lo1_reg [3];
    coord_t hi1_reg [3];
    logic   v1_reg;

    // two-level compare tree per axis
    always_comb
    begin
        coord_t lo_a, lo_b, hi_a, hi_b;
        for (int a = 0; a < 3; a++)
        begin
            lo_a = (p_in[1][a] < p_in[0][a]) ? p_in[1][a] : p_in[0][a];
            lo_b = (p_in[3][a] < p_in[2][a]) ? p_in[3][a] : p_in[2][a];
            hi_a = (p_in[1][a] > p_in[0][a]) ? p_in[1][a] : p_in[0][a];
            hi_b = (p_in[3][a] > p_in[2][a]) ? p_in[3][a] : p_in[2][a];
            lo_next[a] = (lo_b < lo_a) ? lo_b : lo_a;
            hi_next[a] = (hi_b > hi_a) ? hi_b : hi_a;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p_in;
        lo1_reg <= lo_next;
        hi1_reg <= hi_next;
    end

    // ---------------- stage 2: |2p - (min+max)| ----------------
    logic [W-1:0] mag_next [4][3];
    logic [W-1:0] mag2_reg [4][3];
    box_t         box_next;
    box_t         box2_reg;
    logic         v2_reg;

    always_comb
    begin
        logic signed [W:0]   sum;
        logic signed [W+1:0] d;
        logic signed [W+1:0] d_abs;
        for (int v = 0; v < 4; v++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum = {lo1_reg[a][W-1], lo1_reg[a]} + {hi1_reg[a][W-1], hi1_reg[a]};
                d   = {p1_reg[v][a][W-1], p1_reg[v][a], 1'b0} - {sum[W], sum};
                d_abs = d[W+1] ? -d : d;
                // |d| never exceeds max-min, so it fits the coordinate width
                mag_next[v][a] = d_abs[W-1:0];
            end
        end
    end

    always_comb
    begin
        box_next.box_min_x = lo1_reg[0];
        box_next.box_min_y = lo1_reg[1];
        box_next.box_min_z = lo1_reg[2];
        box_next.box_max_x = hi1_reg[0];
        box_next.box_max_y = hi1_reg[1];
        box_next.box_max_z = hi1_reg[2];
    end

    always_ff @(posedge clk)
    begin
        mag2_reg <= mag_next;
        box2_reg <= box_next;
    end

    // ---------------- stage 3: squares ----------------
    logic [SQ_BITS-1:0] sq3_reg [4][3];
    box_t               box3_reg;
    logic               v3_reg;

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 4; v++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq3_reg[v][a] <= SQ_BITS'(mag2_reg[v][a]) * SQ_BITS'(mag2_reg[v][a]);
            end
        end
        box3_reg <= box2_reg;
    end

    // ---------------- stage 4: quarter sums per vertex ----------------
    // squares are 0 or 1 mod 4, so the dropped low bits never carry
    logic [SQ_BITS-1:0] q_next [4];
    logic [SQ_BITS-1:0] q4_reg [4];
    box_t               box4_reg;
    logic               v4_reg;

    always_comb
    begin
        for (int v = 0; v < 4; v++)
        begin
            q_next[v] = (sq3_reg[v][0] >> 2) + (sq3_reg[v][1] >> 2) + (sq3_reg[v][2] >> 2);
        end
    end

    always_ff @(posedge clk)
    begin
        q4_reg   <= q_next;
        box4_reg <= box3_reg;
    end

    // ---------------- stage 5: largest sum ----------------
    logic [SQ_BITS-1:0] best_a;
    logic [SQ_BITS-1:0] best_b;
    logic [SQ_BITS-1:0] best_next;
    logic [SQ_BITS-1:0] best5_reg;
    box_t               box5_reg;
    logic               v5_reg;

    assign best_a    = (q4_reg[1] > q4_reg[0]) ? q4_reg[1] : q4_reg[0];
    assign best_b    = (q4_reg[3] > q4_reg[2]) ? q4_reg[3] : q4_reg[2];
    assign best_next = (best_b > best_a) ? best_b : best_a;

    always_ff @(posedge clk)
    begin
        best5_reg <= best_next;
        box5_reg  <= box4_reg;
    end

    // valid bits for the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- square root and result ----------------
    logic         rt_valid;
    logic [W-1:0] rt_root;
    box_t         rt_box;

    tbr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .radicand  (best5_reg),
        .box_in    (box5_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .box_out   (rt_box)
    );

    assign done = rt_valid;

    always_comb
    begin
        bound.box_min_x     = rt_box.box_min_x;
        bound.box_min_y     = rt_box.box_min_y;
        bound.box_min_z     = rt_box.box_min_z;
        bound.box_max_x     = rt_box.box_max_x;
        bound.box_max_y     = rt_box.box_max_y;
        bound.box_max_z     = rt_box.box_max_z;
        bound.sphere_radius = rt_root;
    end

    // compare tree must give an ordered box on every axis
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (lo1_reg[0] <= hi1_reg[0]) && (lo1_reg[1] <= hi1_reg[1])
                && (lo1_reg[2] <= hi1_reg[2]))
        else $error("box min above max");

    // selected sum dominates every vertex sum of the previous cycle
    a_best_max: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (best5_reg >= $past(q4_reg[0])) && (best5_reg >= $past(q4_reg[1]))
                && (best5_reg >= $past(q4_reg[2])) && (best5_reg >= $past(q4_reg[3])))
        else $error("largest distance selection wrong");

endmodule

// File: tb/testbench.sv
// Self-checking bench for tetrahedron_box_and_radius: directed corner cases, then random
// tetrahedra under several sender gap rates, every result word compared with a predictor.
// Depends on tbr_pkg and the RTL of tetrahedron_box_and_radius.
module testbench;

    import tbr_pkg::*;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
    localparam int     DRAIN_CYCLES = 40;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    tet_t   tet   = '0;
    logic   busy;
    logic   done;
    bound_t bound;

    bound_t bounds_due[$];
    bound_t bound_want;
    int     mismatches = 0;

    tetrahedron_box_and_radius u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .tet   (tet),
        .busy  (busy),
        .done  (done),
        .bound (bound)
    );

    // 10-unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Box per axis, then radius from the largest doubled offset to the box centre
    function automatic bound_t predict_bound(input tet_t t);
        longint       pt[4][3];
        longint       lo[3];
        longint       hi[3];
        longint       off;
        longint unsigned sum_sq;
        longint unsigned widest;
        bound_t       b;
        for (int v = 0; v < 4; v++)
            for (int a = 0; a < 3; a++)
                pt[v][a] = longint'(coord_t'(t[(11 - 3*v - a)*COORD_BITS +: COORD_BITS]));
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = pt[0][a];
            hi[a] = pt[0][a];
            for (int v = 1; v < 4; v++)
            begin
                if (pt[v][a] < lo[a]) lo[a] = pt[v][a];
                if (pt[v][a] > hi[a]) hi[a] = pt[v][a];
            end
        end
        widest = 0;
        for (int v = 0; v < 4; v++)
        begin
            sum_sq = 0;
            for (int a = 0; a < 3; a++)
            begin
                off    = 2 * pt[v][a] - (lo[a] + hi[a]);
                sum_sq += longint'(off * off);
            end
            if (sum_sq > widest)
                widest = sum_sq;
        end
        b.box_min_x     = coord_t'(lo[0]);
        b.box_min_y     = coord_t'(lo[1]);
        b.box_min_z     = coord_t'(lo[2]);
        b.box_max_x     = coord_t'(hi[0]);
        b.box_max_y     = coord_t'(hi[1]);
        b.box_max_z     = coord_t'(hi[2]);
        b.sphere_radius = COORD_BITS'(floor_root(widest >> 2));
        return b;
    endfunction

    function automatic tet_t pack_tet(input coord_t c[12]);
        return tet_t'({c[0], c[1], c[2], c[3], c[4], c[5],
                       c[6], c[7], c[8], c[9], c[10], c[11]});
    endfunction

    // Random tetrahedron: full range, tight cluster, shared vertices or corner values
    function automatic tet_t random_tet();
        coord_t c[12];
        coord_t base;
        int     pick;
        int     src;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            foreach (c[i]) c[i] = coord_t'($urandom);
        end
        else if (pick < 70)
        begin
            for (int a = 0; a < 3; a++)
            begin
                base = coord_t'($urandom);
                for (int v = 0; v < 4; v++)
                    c[3*v + a] = base + coord_t'($urandom_range(0, 511)) - coord_t'(256);
            end
        end
        else if (pick < 85)
        begin
            foreach (c[i]) c[i] = coord_t'($urandom);
            for (int v = 1; v < 4; v++)
                if ($urandom_range(0, 1))
                begin
                    src = $urandom_range(0, v - 1);
                    for (int a = 0; a < 3; a++) c[3*v + a] = c[3*src + a];
                end
        end
        else
        begin
            foreach (c[i])
                case ($urandom_range(0, 4))
                    0: c[i] = COORD_MIN;
                    1: c[i] = COORD_MAX;
                    2: c[i] = '0;
                    3: c[i] = '1;
                    default: c[i] = coord_t'($urandom);
                endcase
        end
        return pack_tet(c);
    endfunction

    // Offer one word, wait for acceptance, record its bound; optional gap afterwards
    task automatic send_tet(input tet_t t, input int gap_pct);
        start <= 1'b1;
        tet   <= t;
        do
            @(posedge clk);
        while (busy);
        bounds_due.push_back(predict_bound(t));
        // each following cycle stays idle with the given chance
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] want,
                               input logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: every done strobe is matched with the oldest outstanding bound
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (bounds_due.size() == 0)
            begin
                $display("%0t: result with none outstanding, expected nothing actual %h",
                         $time, bound);
                mismatches++;
            end
            else
            begin
                bound_want = bounds_due.pop_front();
                check_field("box_min_x", bound_want.box_min_x, bound.box_min_x);
                check_field("box_min_y", bound_want.box_min_y, bound.box_min_y);
                check_field("box_min_z", bound_want.box_min_z, bound.box_min_z);
                check_field("box_max_x", bound_want.box_max_x, bound.box_max_x);
                check_field("box_max_y", bound_want.box_max_y, bound.box_max_y);
                check_field("box_max_z", bound_want.box_max_z, bound.box_max_z);
                check_field("sphere_radius", bound_want.sphere_radius, bound.sphere_radius);
            end
        end
    end

    // Corners, bit patterns, coincident and flat tetrahedra
    task automatic test_directed();
        coord_t c[12];
        coord_t p;
        foreach (c[i]) c[i] = '0;
        send_tet(pack_tet(c), 0);
        foreach (c[i]) c[i] = COORD_MAX;
        send_tet(pack_tet(c), 0);
        foreach (c[i]) c[i] = COORD_MIN;
        send_tet(pack_tet(c), 30);
        foreach (c[i]) c[i] = '1;
        send_tet(pack_tet(c), 0);
        // opposite corners of the full range: largest radius
        c = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
              '0, '0, '0, '0, '0, '0};
        send_tet(pack_tet(c), 0);
        c = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN};
        send_tet(pack_tet(c), 50);
        c = '{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
              COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN};
        send_tet(pack_tet(c), 0);
        // alternating bit patterns so every bit toggles
        foreach (c[i]) c[i] = (i % 2) ? coord_t'(24'h555555) : coord_t'(24'hAAAAAA);
        send_tet(pack_tet(c), 0);
        foreach (c[i]) c[i] = (i % 2) ? coord_t'(24'hAAAAAA) : coord_t'(24'h555555);
        send_tet(pack_tet(c), 0);
        // all four vertices coincident: degenerate box, zero radius
        for (int a = 0; a < 3; a++) c[a] = coord_t'($urandom);
        for (int v = 1; v < 4; v++)
            for (int a = 0; a < 3; a++) c[3*v + a] = c[a];
        send_tet(pack_tet(c), 0);
        // three coincident, one apart
        c[9] = c[0] + coord_t'(7); c[10] = c[1] - coord_t'(3); c[11] = c[2] + coord_t'(1);
        send_tet(pack_tet(c), 90);
        // flat in z, spread in x and y
        p = coord_t'($urandom);
        foreach (c[i]) c[i] = ((i % 3) == 2) ? p : coord_t'($urandom);
        send_tet(pack_tet(c), 0);
        // unit steps on one axis only: odd box width leaves a half-unit centre
        c = '{'0, '0, '0, coord_t'(1), '0, '0, coord_t'(2), '0, '0, coord_t'(3), '0, '0};
        send_tet(pack_tet(c), 0);
        c = '{'0, '0, '0, coord_t'(1), '0, '0, '0, '0, '0, '0, '0, '0};
        send_tet(pack_tet(c), 0);
        c = '{'1, '1, '1, '0, '0, '0, '1, '0, '1, '0, '1, '0};
        send_tet(pack_tet(c), 0);
    endtask

    task automatic test_random(input int count, input int gap_pct);
        for (int n = 0; n < count; n++)
            send_tet(random_tet(), gap_pct);
    endtask

    // Test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400, 0);
        test_random(350, 71);
        test_random(400, 14);
        start <= 1'b0;

        while (bounds_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/tbr_pkg.sv
src/tbr_isqrt.sv
src/tetrahedron_box_and_radius.sv
tb/testbench.sv
